@@ hdl/mrs_pkg.sv @@
// Shared types, constants and CRC helper for the Modbus RTU register slave.
package mrs_pkg;

  // Input item kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_END    = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_REG_BASE   = 2'd1;

  // Function codes and exception bytes
  localparam logic [7:0] FN_READ_REGS  = 8'h03;
  localparam logic [7:0] FN_WRITE_REG  = 8'h06;
  localparam logic [7:0] EXC_BAD_FUNC  = 8'h03;
  localparam logic [7:0] EXC_BAD_ADDR  = 8'h04;

  // CRC16, reflected form
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // floor(s*33/20) = (s * 33 * ceil(2^23/20)) >> 23, exact for 12-bit s
  localparam logic [23:0] SCALE_MUL   = 24'd13841223;
  localparam int          SCALE_SHIFT = 23;

  // Reply byte index width (longest read reply is 5 + 2*NUM_REGS bytes)
  localparam int TXW = 7;

  // Reply modes
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_EXC   = 2'd2
  } mode_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;
    logic sample;
    logic frame_start;
    logic scan;
    logic calc;
    logic exec;
    logic send;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic frame_ok;
    logic slot_free;
    logic last_byte;
  } dp_sts_t;

  // One byte through the reflected CRC16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hdl/modbus_rtu_register_slave_top.sv @@
// Top level: Modbus RTU register slave, controller plus datapath.
// Byte and sample items are accepted only in idle; a new item is accepted the next cycle.
// Frame end: N received bytes are scanned via the one-port store; then reply bytes
// (up to 5+2*NUM_REGS) leave the output register one per cycle as out_ready allows.
// Synchronous active-low reset clears control state, configuration and register file;
// the receive store needs no clearing pass; scans read only below the fill count.
module modbus_rtu_register_slave_top #(
  parameter int RX_DEPTH = 64,
  parameter int NUM_REGS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic [4:0]  in_channel,
  input  logic [11:0] in_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_framed,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mrs_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrs_dp #(
    .RX_DEPTH (RX_DEPTH),
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_rx_byte  (in_rx_byte),
    .in_channel  (in_channel),
    .in_sample   (in_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_tx_byte (out_tx_byte),
    .out_framed  (out_framed),
    .out_last    (out_last)
  );

endmodule

@@ hdl/mrs_ctrl.sv @@
// Frame sequencer: accepts items and steps the datapath through scan, check, reply.
module mrs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  mrs_pkg::dp_sts_t   sts,
  output mrs_pkg::ctrl_cmd_t cmd
);
  import mrs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  // Commands
  always_comb begin
    cmd             = '0;
    cmd.store       = acc && (in_kind == KIND_BYTE);
    cmd.sample      = acc && (in_kind == KIND_SAMPLE);
    cmd.frame_start = acc && (in_kind == KIND_END);
    cmd.scan        = (state_r == ST_SCAN);
    cmd.calc        = (state_r == ST_CHECK);
    cmd.exec        = (state_r == ST_EXEC);
    cmd.send        = (state_r == ST_SEND);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd.frame_start) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = sts.frame_ok ? ST_EXEC : ST_IDLE;
      ST_EXEC:  state_nxt = ST_SEND;
      ST_SEND:  if (sts.slot_free && sts.last_byte) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.frame_start |=> state_r == ST_SCAN) else $error("frame end did not start scan");
  a_busy_send: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |-> !in_ready) else $error("item taken while replying");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
`endif

endmodule

@@ hdl/mrs_dp.sv @@
// Datapath: receive store, register file, frame check, reply byte generation.
module mrs_dp #(
  parameter int RX_DEPTH = 64,
  parameter int NUM_REGS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrs_pkg::ctrl_cmd_t cmd,
  output mrs_pkg::dp_sts_t   sts,
  input  logic [7:0]         in_rx_byte,
  input  logic [4:0]         in_channel,
  input  logic [11:0]        in_sample,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_framed,
  output logic               out_last
);
  import mrs_pkg::*;

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW = $clog2(RX_DEPTH + 1);
  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Configuration
  logic [7:0]  slave_addr_r;
  logic [15:0] reg_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= 8'd1;
      reg_base_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDR: slave_addr_r <= cfg_wdata[7:0];
        CFG_REG_BASE:   reg_base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Receive store; the scan reads only bytes below the captured fill count
  logic [7:0]    rx_mem [RX_DEPTH];
  logic [CW-1:0] count_r, len_r, scan_idx_r, rd_idx_r;
  logic [7:0]    rd_data_r;
  logic          rd_vld_r;
  logic          issue;

  assign issue = cmd.scan && (scan_idx_r < len_r);

  always_ff @(posedge clk) begin
    if (cmd.store && (count_r < CW'(RX_DEPTH))) begin
      rx_mem[count_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= rx_mem[scan_idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      len_r      <= '0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (cmd.store && (count_r < CW'(RX_DEPTH))) count_r <= count_r + 1'b1;
      if (cmd.frame_start) begin
        len_r      <= count_r;
        count_r    <= '0;
        scan_idx_r <= '0;
      end else if (issue) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      rd_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_idx_r;
  end

  // Scan: header capture, CRC over the body, trailing CRC capture
  logic [7:0]  hdr_r [6];
  logic [15:0] rx_crc_r;
  logic [7:0]  crc_lo_r, crc_hi_r;

  always_ff @(posedge clk) begin
    if (cmd.frame_start) begin
      for (int i = 0; i < 6; i++) hdr_r[i] <= '0;
      rx_crc_r <= CRC_INIT;
    end else if (rd_vld_r) begin
      if (rd_idx_r < CW'(6)) hdr_r[rd_idx_r[2:0]] <= rd_data_r;
      if ((rd_idx_r + CW'(2)) < len_r) rx_crc_r <= crc_byte(rx_crc_r, rd_data_r);
      if (rd_idx_r == len_r - CW'(2)) crc_lo_r <= rd_data_r;
      if (rd_idx_r == len_r - CW'(1)) crc_hi_r <= rd_data_r;
    end
  end

  assign sts.scan_done = !(scan_idx_r < len_r) && !rd_vld_r;
  assign sts.frame_ok  = (len_r >= CW'(4)) && (hdr_r[0] == slave_addr_r) &&
                         (crc_lo_r == rx_crc_r[7:0]) && (crc_hi_r == rx_crc_r[15:8]);

  // Operand decode
  logic [15:0] addr_r, val_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr_r <= {hdr_r[2], hdr_r[3]} - reg_base_r;
      val_r  <= {hdr_r[4], hdr_r[5]};
    end
  end

  // Register file and sample scaling
  logic [15:0] regs_r [NUM_REGS];
  logic [35:0] scaled;
  logic        rd_range_ok, wr_range_ok;

  assign scaled      = {24'd0, in_sample} * {12'd0, SCALE_MUL};
  assign rd_range_ok = ({1'b0, addr_r} + {1'b0, val_r}) <= 17'(NUM_REGS);
  assign wr_range_ok = addr_r < 16'(NUM_REGS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cmd.sample && ({1'b0, in_channel} < 6'(NUM_REGS))) begin
      regs_r[in_channel[RW-1:0]] <= 16'(scaled[35:SCALE_SHIFT]);
    end else if (cmd.exec && (hdr_r[1] == FN_WRITE_REG) && wr_range_ok) begin
      regs_r[addr_r[RW-1:0]] <= val_r;
    end
  end

  // Reply setup
  mode_t          mode_r;
  logic [7:0]     exc_r;
  logic [TXW-1:0] body_len_r, tx_idx_r;
  logic [15:0]    tx_crc_r;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tx_idx_r   <= '0;
      body_len_r <= TXW'(6);
      if (hdr_r[1] == FN_READ_REGS) begin
        mode_r     <= rd_range_ok ? MODE_READ : MODE_EXC;
        exc_r      <= EXC_BAD_ADDR;
        body_len_r <= TXW'(3) + {val_r[5:0], 1'b0};
      end else if (hdr_r[1] == FN_WRITE_REG) begin
        mode_r <= wr_range_ok ? MODE_WRITE : MODE_EXC;
        exc_r  <= EXC_BAD_ADDR;
      end else begin
        mode_r <= MODE_EXC;
        exc_r  <= EXC_BAD_FUNC;
      end
    end else if (cmd.send && sts.slot_free) begin
      tx_idx_r <= tx_idx_r + 1'b1;
    end
  end

  // Current reply byte
  logic [TXW-1:0] d_idx;
  logic [15:0]    ri_sum;
  logic [15:0]    rword;
  logic [7:0]     body_byte, cur_byte;
  logic           in_body;

  assign d_idx  = tx_idx_r - TXW'(3);
  assign ri_sum = addr_r + 16'(d_idx[TXW-1:1]);
  assign rword  = regs_r[ri_sum[RW-1:0]];
  assign in_body = tx_idx_r < body_len_r;

  always_comb begin
    body_byte = '0;
    if (tx_idx_r == TXW'(0)) begin
      body_byte = slave_addr_r;
    end else if (mode_r == MODE_READ) begin
      if (tx_idx_r == TXW'(1))      body_byte = FN_READ_REGS;
      else if (tx_idx_r == TXW'(2)) body_byte = {val_r[6:0], 1'b0};
      else                          body_byte = d_idx[0] ? rword[7:0] : rword[15:8];
    end else begin
      if (tx_idx_r == TXW'(1)) body_byte = FN_WRITE_REG;
      else                     body_byte = hdr_r[tx_idx_r[2:0]];
    end
  end

  always_comb begin
    if (in_body)                   cur_byte = body_byte;
    else if (tx_idx_r == body_len_r) cur_byte = tx_crc_r[7:0];
    else                           cur_byte = tx_crc_r[15:8];
  end

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.last_byte = (mode_r == MODE_EXC) || (tx_idx_r == body_len_r + TXW'(1));

  // Reply CRC
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      tx_crc_r <= CRC_INIT;
    end else if (cmd.send && sts.slot_free && in_body) begin
      tx_crc_r <= crc_byte(tx_crc_r, body_byte);
    end
  end

  // Output register
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.send && sts.slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send && sts.slot_free) begin
      out_tx_byte <= (mode_r == MODE_EXC) ? exc_r : cur_byte;
      out_framed  <= (mode_r != MODE_EXC);
      out_last    <= sts.last_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> rd_idx_r < len_r) else $error("scan read past frame");
  a_reg_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.send && mode_r == MODE_READ && in_body && tx_idx_r > TXW'(2)) |->
      ri_sum < 16'(NUM_REGS)) else $error("register read out of range");
  a_no_store_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> !cmd.store) else $error("byte stored during scan");
`endif

endmodule

@@ tb/sv/modbus_rtu_register_slave_top_tb.sv @@
// Testbench for the Modbus RTU register slave: directed table, random frames, scoreboard.
module modbus_rtu_register_slave_top_tb;
  import mrs_pkg::*;

  localparam int RXD  = 64;
  localparam int NREG = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [7:0]  in_rx_byte;
  logic [4:0]  in_channel;
  logic [11:0] in_sample;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_tx_byte;
  logic        out_framed;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  modbus_rtu_register_slave_top #(.RX_DEPTH(RXD), .NUM_REGS(NREG)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_rx_byte(in_rx_byte), .in_channel(in_channel), .in_sample(in_sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_tx_byte(out_tx_byte),
    .out_framed(out_framed), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       framed;
    logic       last;
  } tx_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_byte;
    logic [4:0]  channel;
    logic [11:0] sample;
  } rx_item_t;

  // Directed row: item plus optional typed-in bare reply
  typedef struct packed {
    rx_item_t   item;
    logic       has_exp;
    logic [7:0] exp_byte;
  } dir_row_t;

  // Predictor state
  logic [7:0]  slave_addr_q;
  logic [15:0] reg_base_q;
  logic [7:0]  rx_store[RXD];
  int          rx_count;
  logic [15:0] reg_file[NREG];

  tx_item_t tx_expected[$];
  rx_item_t send_q[$];
  tx_item_t last_got;

  int errors;
  int n_items;
  int n_results;
  int n_frames;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic logic [7:0] rx_at(int i);
    return (i < RXD) ? rx_store[i] : 8'h00;
  endfunction

  function automatic void push_bare(logic [7:0] b);
    tx_expected.push_back('{tx_byte: b, framed: 1'b0, last: 1'b1});
  endfunction

  function automatic void push_reply(logic [7:0] buf_q[$]);
    logic [15:0] crc;
    crc = 16'hFFFF;
    foreach (buf_q[i]) crc = crc_step(crc, buf_q[i]);
    buf_q.push_back(crc[7:0]);
    buf_q.push_back(crc[15:8]);
    foreach (buf_q[i])
      tx_expected.push_back('{tx_byte: buf_q[i], framed: 1'b1, last: (i == buf_q.size() - 1)});
  endfunction

  // Answer one frame from the collected bytes
  function automatic void answer_frame();
    logic [15:0] crc;
    logic [15:0] idx;
    logic [15:0] val;
    logic [7:0]  rep[$];
    int          len;
    len = rx_count;
    if (len < 4 || rx_at(0) != slave_addr_q) return;
    crc = 16'hFFFF;
    for (int i = 0; i + 2 < len; i++) crc = crc_step(crc, rx_at(i));
    if (rx_at(len - 2) != crc[7:0] || rx_at(len - 1) != crc[15:8]) return;
    idx = {rx_at(2), rx_at(3)} - reg_base_q;
    val = {rx_at(4), rx_at(5)};
    if (rx_at(1) == FN_READ_REGS) begin
      if (int'(idx) + int'(val) > NREG) begin
        push_bare(EXC_BAD_ADDR);
        return;
      end
      rep = '{slave_addr_q, FN_READ_REGS, 8'(val * 2)};
      for (int i = 0; i < val; i++) begin
        rep.push_back(reg_file[idx + i][15:8]);
        rep.push_back(reg_file[idx + i][7:0]);
      end
      push_reply(rep);
    end else if (rx_at(1) == FN_WRITE_REG) begin
      if (idx >= NREG) begin
        push_bare(EXC_BAD_ADDR);
        return;
      end
      reg_file[idx] = val;
      rep = '{slave_addr_q, FN_WRITE_REG, rx_at(2), rx_at(3), rx_at(4), rx_at(5)};
      push_reply(rep);
    end else begin
      push_bare(EXC_BAD_FUNC);
    end
  endfunction

  function automatic void predict_item(rx_item_t it);
    case (it.kind)
      KIND_BYTE: if (rx_count < RXD) begin
        rx_store[rx_count] = it.rx_byte;
        rx_count++;
      end
      KIND_END: begin
        answer_frame();
        n_frames++;
        foreach (rx_store[i]) rx_store[i] = 8'h00;
        rx_count = 0;
      end
      KIND_SAMPLE: if (it.channel < NREG) reg_file[it.channel] = 16'((it.sample * 33) / 20);
      default: ;
    endcase
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #8000000;
    $display("TIMEOUT at %0t", $time);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sender: offers queued items, idles at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item({in_kind, in_rx_byte, in_channel, in_sample});
        n_items++;
      end
      if ((!in_valid || in_ready) && send_q.size() > 0 &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        rx_item_t it;
        it = send_q.pop_front();
        in_valid   <= 1'b1;
        in_kind    <= it.kind;
        in_rx_byte <= it.rx_byte;
        in_channel <= it.channel;
        in_sample  <= it.sample;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted result, stalls at random or for a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tx_item_t got, want;
        got = '{tx_byte: out_tx_byte, framed: out_framed, last: out_last};
        last_got = got;
        n_results++;
        if (tx_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected result byte=%h framed=%b last=%b",
                   $time, got.tx_byte, got.framed, got.last);
        end else begin
          want = tx_expected.pop_front();
          if (got.tx_byte != want.tx_byte) begin
            errors++;
            $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
          end
          if (got.framed != want.framed) begin
            errors++;
            $display("%0t: framed expected %b actual %b", $time, want.framed, got.framed);
          end
          if (got.last != want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_byte(logic [7:0] b);
    send_q.push_back('{kind: KIND_BYTE, rx_byte: b, channel: 5'($urandom),
                       sample: 12'($urandom)});
  endtask

  task automatic queue_end();
    send_q.push_back('{kind: KIND_END, rx_byte: 8'($urandom), channel: 5'($urandom),
                       sample: 12'($urandom)});
  endtask

  // Request frame with correct CRC (or a corrupted one), then frame end
  task automatic queue_frame(logic [7:0] body[$], bit bad_crc);
    logic [15:0] crc;
    crc = 16'hFFFF;
    foreach (body[i]) begin
      crc = crc_step(crc, body[i]);
      queue_byte(body[i]);
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15, 0));
    queue_byte(crc[7:0]);
    queue_byte(crc[15:8]);
    queue_end();
  endtask

  task automatic drain();
    while (send_q.size() > 0 || in_valid || tx_expected.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SLAVE_ADDR) slave_addr_q = data[7:0];
    else if (idx == CFG_REG_BASE) reg_base_q = data;
  endtask

  // One random frame: mostly valid reads and writes, some noise
  task automatic random_frame();
    logic [7:0]  body[$];
    logic [15:0] a;
    int          sel;
    sel = $urandom_range(99, 0);
    a = reg_base_q + 16'($urandom_range(NREG + 1, 0));
    if (sel < 10) a = 16'($urandom);
    if (sel < 40) begin
      body = '{slave_addr_q, FN_READ_REGS, a[15:8], a[7:0], 8'h00,
               8'($urandom_range(NREG, 0))};
      queue_frame(body, $urandom_range(19, 0) == 0);
    end else if (sel < 70) begin
      body = '{slave_addr_q, FN_WRITE_REG, a[15:8], a[7:0], 8'($urandom), 8'($urandom)};
      queue_frame(body, $urandom_range(19, 0) == 0);
    end else if (sel < 78) begin
      body = '{slave_addr_q, 8'($urandom), 8'($urandom), 8'($urandom)};
      queue_frame(body, 0);
    end else if (sel < 84) begin
      body = '{8'($urandom), FN_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h01};
      queue_frame(body, 0);
    end else if (sel < 90) begin
      repeat ($urandom_range(6, 0)) queue_byte(8'($urandom));
      queue_end();
    end else if (sel < 96) begin
      send_q.push_back('{kind: KIND_SAMPLE, rx_byte: 8'($urandom),
                         channel: 5'($urandom), sample: 12'($urandom)});
    end else begin
      send_q.push_back('{kind: 2'd3, rx_byte: 8'($urandom), channel: 5'($urandom),
                         sample: 12'($urandom)});
    end
  endtask

  dir_row_t dir_rows[$];

  task automatic add_row(rx_item_t it, logic has_exp, logic [7:0] eb);
    dir_rows.push_back('{item: it, has_exp: has_exp, exp_byte: eb});
  endtask

  task automatic row_byte(logic [7:0] b);
    add_row('{kind: KIND_BYTE, rx_byte: b, channel: 5'd0, sample: 12'd0}, 1'b0, 8'h00);
  endtask

  // Directed rows with CRC appended; the end row may carry a typed-in bare byte
  task automatic row_frame(logic [7:0] body[$], logic has_exp, logic [7:0] eb);
    logic [15:0] crc;
    crc = 16'hFFFF;
    foreach (body[i]) begin
      crc = crc_step(crc, body[i]);
      row_byte(body[i]);
    end
    row_byte(crc[7:0]);
    row_byte(crc[15:8]);
    add_row('{kind: KIND_END, rx_byte: 8'hFF, channel: 5'h1F, sample: 12'hFFF}, has_exp, eb);
  endtask

  initial begin
    int phase;
    int res_before;
    errors = 0; n_items = 0; n_results = 0; n_frames = 0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_kind = '0; in_rx_byte = '0; in_channel = '0; in_sample = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    slave_addr_q = 8'd1; reg_base_q = 16'd0; rx_count = 0;
    foreach (rx_store[i]) rx_store[i] = 8'h00;
    foreach (reg_file[i]) reg_file[i] = 16'h0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: samples at extremes, reads, writes, errors, short frame, kind 3
    add_row('{kind: KIND_SAMPLE, rx_byte: 8'h00, channel: 5'd0, sample: 12'hFFF}, 1'b0, 8'h0);
    add_row('{kind: KIND_SAMPLE, rx_byte: 8'hFF, channel: 5'd7, sample: 12'h001}, 1'b0, 8'h0);
    add_row('{kind: KIND_SAMPLE, rx_byte: 8'h55, channel: 5'd31, sample: 12'hAAA}, 1'b0, 8'h0);
    add_row('{kind: 2'd3, rx_byte: 8'hFF, channel: 5'd31, sample: 12'hFFF}, 1'b0, 8'h0);
    row_frame('{8'h01, FN_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h08}, 1'b0, 8'h0);
    row_frame('{8'h01, FN_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h0);
    row_frame('{8'h01, FN_READ_REGS, 8'h00, 8'h07, 8'h00, 8'h02}, 1'b1, EXC_BAD_ADDR);
    row_frame('{8'h01, FN_WRITE_REG, 8'h00, 8'h03, 8'hFF, 8'hFF}, 1'b0, 8'h0);
    row_frame('{8'h01, FN_WRITE_REG, 8'hFF, 8'hFF, 8'h12, 8'h34}, 1'b1, EXC_BAD_ADDR);
    row_frame('{8'h01, 8'h7F}, 1'b1, EXC_BAD_FUNC);
    row_frame('{8'h02, FN_READ_REGS, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0, 8'h0);
    row_frame('{8'h01}, 1'b0, 8'h0);

    foreach (dir_rows[r]) begin
      res_before = n_results;
      send_q.push_back(dir_rows[r].item);
      drain();
      // Typed-in bare bytes are checked against what came out
      if (dir_rows[r].has_exp) begin
        if (n_results != res_before + 1 || last_got.tx_byte != dir_rows[r].exp_byte ||
            last_got.framed != 1'b0) begin
          errors++;
          $display("%0t: expected bare %h actual %h (%0d results)", $time,
                   dir_rows[r].exp_byte, last_got.tx_byte, n_results - res_before);
        end
      end
    end
    // Overlong frame (store full) and too-short frame
    repeat (70) queue_byte(8'($urandom));
    queue_end();
    queue_byte(8'h01); queue_byte(8'h03);
    queue_end();
    drain();

    // Random phases over several settings and idling mixes
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_cfg(CFG_SLAVE_ADDR, 16'd247);
        1: write_cfg(CFG_REG_BASE, 16'hFFFC);
        2: write_cfg(CFG_REG_BASE, 16'd1000);
        3: write_cfg(CFG_SLAVE_ADDR, 16'd1);
        4: write_cfg(2'd3, 16'h00AA);
        default: begin
          write_cfg(CFG_REG_BASE, 16'd0);
          write_cfg(CFG_SLAVE_ADDR, 16'd17);
        end
      endcase
      send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 74 : 0;
      recv_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 20 : 0;
      if (phase == 4) begin
        hold_cycles = 400;
        repeat (3) begin
          queue_frame('{slave_addr_q, FN_READ_REGS, reg_base_q[15:8], reg_base_q[7:0],
                        8'h00, 8'h08}, 0);
        end
      end
      repeat (5) random_frame();
      drain();
    end

    $display("Run covered %0d items, %0d frames, %0d reply bytes checked.",
             n_items, n_frames, n_results);
    $display("Settings: addresses 1/17/247, register bases 0/1000/0xFFFC, idle mixes.");
    if (errors == 0 && tx_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
